>>> rtl/sgb_pkg.sv
// Shared types and constants for the separable Gaussian blur block.
// Used by every module under rtl/ but sgb_ram; depends on nothing.
`default_nettype none

package sgb_pkg;

  // Fixed field and register widths, tap count and rounding constants
  localparam int PIX_W    = 16;
  localparam int COL_W    = 10;
  localparam int ROW_W    = 10;
  localparam int COEF_W   = 17;
  localparam int SIZE_W   = 11;
  localparam int NUM_COEF = 6;
  localparam int CIDX_W   = 3;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int RND_HALF = 32768;

  localparam logic [COEF_W-1:0] COEF0_RESET = 17'd65536;
  localparam logic [SIZE_W-1:0] SIZE_RESET  = 11'd1024;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    REG_COEF_0,
    REG_COEF_1,
    REG_COEF_2,
    REG_COEF_3,
    REG_COEF_4,
    REG_COEF_5,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_VISSUE,
    ST_VWAIT,
    ST_VDONE,
    ST_HISSUE,
    ST_HWAIT,
    ST_HOUT
  } state_t;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pixel;
  } pix_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             last_in_run;
    logic             last_of_image;
  } res_word_t;

  typedef struct packed {
    logic [NUM_COEF-1:0][COEF_W-1:0] coef;
    logic [SIZE_W-1:0]               image_width;
    logic [SIZE_W-1:0]               image_height;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctl_t;

endpackage

`default_nettype wire

>>> rtl/separable_gaussian_blur_top.sv
// Streaming separable Gaussian blur with replicated borders (top level).
// Depends on sgb_pkg, sgb_regs, sgb_mac and sgb_ram.
//
// Pixels enter in raster order on the pix channel; after the bottom row the
// source sends MAX_RADIUS rows of drain words (op = drain) of image_width words
// each. Output runs MAX_RADIUS rows and columns behind the input. Each word
// first gets a vertical pass down its column from the line store (2*MAX_RADIUS
// past rows per column in one RAM), rounded and kept in a (2*MAX_RADIUS+1)-entry window,
// then a horizontal pass over that window gives the result pixels; at the end
// of a row the trailing MAX_RADIUS columns are flushed as well, so one word
// yields up to MAX_RADIUS+1 result words. Words are processed one at a time,
// each through ST_MOD and the vertical pass (ST_VISSUE, ST_VWAIT, ST_VDONE),
// then one horizontal pass (ST_HISSUE, ST_HWAIT, ST_HOUT) per result word; a
// result held off by res_stall holds the block in ST_HOUT. The shared MAC unit
// is fed one tap per cycle in the issue states; the row and column slots come
// from a reciprocal multiply registered in ST_MOD. A finished result waits
// in the output register while the next word is taken. Sizes of 0 act as 1,
// sizes above the maximum act as it. No clearing pass is needed after reset.
`default_nettype none

module separable_gaussian_blur_top #(
  parameter int MAX_RADIUS = 5,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // pixel / drain words in
  input  wire logic                       pix_valid,
  output      logic                       pix_stall,
  input  wire sgb_pkg::pix_word_t         pix_data,
  // result words out
  output      logic                       res_valid,
  input  wire logic                       res_stall,
  output      sgb_pkg::res_word_t         res_data,
  // configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [sgb_pkg::ADDR_W-1:0] paddr,
  input  wire logic [sgb_pkg::DATA_W-1:0] pwdata,
  output      logic [sgb_pkg::DATA_W-1:0] prdata,
  output      logic                       pready
);

  localparam int R          = MAX_RADIUS;
  localparam int SLOTS      = 2 * MAX_RADIUS;
  localparam int TAPS       = SLOTS + 1;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT + MAX_RADIUS);
  localparam int MB         = (XW > YW) ? XW : YW;
  localparam int SW         = $clog2(SLOTS);
  localparam int TW         = $clog2(TAPS);
  localparam int KW         = $clog2(TAPS);
  localparam int HIST_DEPTH = MAX_WIDTH * SLOTS;
  localparam int HAW        = $clog2(HIST_DEPTH);
  localparam int ACC_W      = sgb_pkg::COEF_W + PIXEL_BITS + 4;
  localparam int PIX_W_EXT  = sgb_pkg::PIX_W + PIXEL_BITS;
  // exact floor division by a constant for operands below 2**MB
  localparam int XSH        = MB + $clog2(TAPS);
  localparam int YSH        = MB + $clog2(SLOTS);
  localparam int XMUL       = (2**XSH + TAPS - 1) / TAPS;
  localparam int YMUL       = (2**YSH + SLOTS - 1) / SLOTS;
  localparam int XPW        = MB + XSH + 1;
  localparam int YPW        = MB + YSH + 1;

  sgb_pkg::cfg_t     cfg;
  sgb_pkg::state_t   state, state_next;
  sgb_pkg::mac_ctl_t mac_ctl;

  // position of the next word
  logic [XW-1:0] column_count;
  logic [YW-1:0] row_count;

  // effective frame size and clamped position at accept
  logic [XW:0]   cur_w, wm1;
  logic [YW:0]   cur_h, hr1;
  logic [XW-1:0] x_acc;
  logic [YW-1:0] y_acc;
  logic          in_img, mismatch;
  logic [PIX_W_EXT-1:0] pix_ext;

  // latched per word
  logic [XW:0]           w_r;
  logic [YW:0]           h_r;
  logic [XW-1:0]         x_r;
  logic [YW-1:0]         y_r;
  logic [PIXEL_BITS-1:0] pix_r;
  logic                  in_img_r;

  // slot remainders: x mod TAPS, y mod SLOTS
  logic [XPW-1:0] xprod;
  logic [YPW-1:0] yprod;
  logic [MB-1:0]  xq, yq, xrem, yrem;
  logic [TW-1:0]  rx;
  logic [SW-1:0]  ry;

  // tap sequencing
  logic [KW-1:0] kk;
  logic          wcnt;
  logic [KW-1:0] tap_dist;
  logic [KW+sgb_pkg::CIDX_W-1:0] dist_e;
  logic [sgb_pkg::COEF_W-1:0]    weight;

  // vertical pass addressing
  logic [YW:0]   vsum, vj0, vj, vdf;
  logic [KW:0]   va, vb, vs;
  logic [SW-1:0] vslot;
  logic          v_usepix;
  logic [HAW-1:0] x_base, hist_raddr, hist_waddr;
  logic [PIXEL_BITS-1:0] hist_rdata;
  logic           hist_we;

  // horizontal pass addressing
  logic [XW:0]   hsum, hj0, hj, hdf;
  logic [KW:0]   ha, hb, hs;
  logic [TW-1:0] hslot;
  logic [XW-1:0] c_r, last_r;

  // operand stage ahead of the MAC
  logic                   s1_valid, s1_from_ram, s1_usepix;
  logic [sgb_pkg::COEF_W-1:0] s1_weight;
  logic [PIXEL_BITS-1:0]  s1_win, mac_sample, mac_round;

  logic [PIXEL_BITS-1:0] row_window [TAPS];

  // control decisions
  logic          x_last, h_go, out_free, res_load, finish;
  logic [XW-1:0] col_adv;
  logic [YW-1:0] row_adv;
  logic [YW:0]   ynx;

  sgb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sgb_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (pix_r),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  sgb_mac #(
    .PIX_BITS (PIXEL_BITS),
    .ACC_W    (ACC_W)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mac_ctl),
    .sample  (mac_sample),
    .weight  (s1_weight),
    .rounded (mac_round)
  );

  // Clamp the frame size: zero acts as one, oversize acts as the maximum.
  always_comb begin
    if (cfg.image_width == '0) begin
      cur_w = (XW+1)'(1);
    end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
      cur_w = (XW+1)'(MAX_WIDTH);
    end else begin
      cur_w = (XW+1)'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      cur_h = (YW+1)'(1);
    end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
      cur_h = (YW+1)'(MAX_HEIGHT);
    end else begin
      cur_h = (YW+1)'(cfg.image_height);
    end
    // saturate a position left beyond a shrunk frame
    wm1   = cur_w - (XW+1)'(1);
    hr1   = cur_h + (YW+1)'(R - 1);
    x_acc = ({1'b0, column_count} > wm1) ? wm1[XW-1:0] : column_count;
    y_acc = ({1'b0, row_count} > hr1) ? hr1[YW-1:0] : row_count;
    in_img   = (YW+1)'(y_acc) < cur_h;
    // drain word inside the frame or pixel word in the drain rows: drop it
    mismatch = (pix_data.op == sgb_pkg::OP_DRAIN) == in_img;
    pix_ext  = PIX_W_EXT'(pix_data.pixel);
  end

  // Slot remainders by reciprocal multiply: quotient, then subtract it back.
  always_comb begin
    xprod = XPW'(x_r) * XPW'(XMUL);
    yprod = YPW'(y_r) * YPW'(YMUL);
    xq    = MB'(xprod >> XSH);
    yq    = MB'(yprod >> YSH);
    xrem  = MB'(x_r) - xq * MB'(TAPS);
    yrem  = MB'(y_r) - yq * MB'(SLOTS);
  end

  // Tap weight for the current tap index: distance from the center.
  always_comb begin
    tap_dist = (kk < KW'(R)) ? (KW'(R) - kk) : (kk - KW'(R));
    dist_e   = (KW+sgb_pkg::CIDX_W)'(tap_dist);
    if (32'(tap_dist) < sgb_pkg::NUM_COEF) begin
      weight = cfg.coef[dist_e[sgb_pkg::CIDX_W-1:0]];
    end else begin
      weight = '0;
    end
  end

  // Vertical pass: history row y-2R+kk, clamped to the frame; the newest
  // row comes straight from the word, older rows from slot (y - d) mod SLOTS.
  always_comb begin
    vsum     = (YW+1)'(y_r) + (YW+1)'(kk);
    vj0      = (vsum < (YW+1)'(SLOTS)) ? '0 : vsum - (YW+1)'(SLOTS);
    vj       = (vj0 > h_r - (YW+1)'(1)) ? h_r - (YW+1)'(1) : vj0;
    vdf      = {1'b0, y_r} - vj;
    v_usepix = (vdf == '0);
    va       = (KW+1)'(ry);
    vb       = vdf[KW:0];
    vs       = (va >= vb) ? va - vb : va + (KW+1)'(SLOTS) - vb;
    vslot    = vs[SW-1:0];
    x_base     = HAW'(x_r) * HAW'(SLOTS);
    hist_raddr = x_base + HAW'(vslot);
    hist_waddr = x_base + HAW'(ry);
  end

  // Horizontal pass: window column c-R+kk, clamped to the frame, held in
  // window slot (x - d) mod TAPS.
  always_comb begin
    hsum  = (XW+1)'(c_r) + (XW+1)'(kk);
    hj0   = (hsum < (XW+1)'(R)) ? '0 : hsum - (XW+1)'(R);
    hj    = (hj0 > w_r - (XW+1)'(1)) ? w_r - (XW+1)'(1) : hj0;
    hdf   = {1'b0, x_r} - hj;
    ha    = (KW+1)'(rx);
    hb    = hdf[KW:0];
    hs    = (ha >= hb) ? ha - hb : ha + (KW+1)'(TAPS) - hb;
    hslot = hs[TW-1:0];
  end

  // Operand select for the MAC.
  always_comb begin
    if (s1_from_ram) begin
      mac_sample = s1_usepix ? pix_r : hist_rdata;
    end else begin
      mac_sample = s1_win;
    end
  end

  // End-of-word bookkeeping and next position.
  always_comb begin
    x_last = ({1'b0, x_r} == w_r - (XW+1)'(1));
    h_go   = (32'(y_r) >= R) && (x_last || (32'(x_r) >= R));
    ynx    = {1'b0, y_r} + (YW+1)'(1);
    if ({1'b0, x_r} >= w_r - (XW+1)'(1)) begin
      col_adv = '0;
      row_adv = (ynx >= h_r + (YW+1)'(R)) ? '0 : ynx[YW-1:0];
    end else begin
      col_adv = x_r + XW'(1);
      row_adv = y_r;
    end
  end

  // Sequencer: next state and strobes.
  always_comb begin
    state_next    = state;
    out_free      = !res_valid || !res_stall;
    res_load      = 1'b0;
    finish        = 1'b0;
    hist_we       = 1'b0;
    pix_stall     = (state != sgb_pkg::ST_IDLE);
    mac_ctl.valid = s1_valid;
    mac_ctl.clear = 1'b0;
    unique case (state)
      sgb_pkg::ST_IDLE: begin
        if (pix_valid && !mismatch) begin
          state_next = sgb_pkg::ST_MOD;
        end
      end
      sgb_pkg::ST_MOD: begin
        state_next = sgb_pkg::ST_VISSUE;
      end
      sgb_pkg::ST_VISSUE: begin
        mac_ctl.clear = (kk == '0);
        if (kk == KW'(SLOTS)) begin
          state_next = sgb_pkg::ST_VWAIT;
        end
      end
      sgb_pkg::ST_VWAIT: begin
        if (wcnt) begin
          state_next = sgb_pkg::ST_VDONE;
        end
      end
      sgb_pkg::ST_VDONE: begin
        hist_we = in_img_r;
        if (h_go) begin
          state_next = sgb_pkg::ST_HISSUE;
        end else begin
          finish     = 1'b1;
          state_next = sgb_pkg::ST_IDLE;
        end
      end
      sgb_pkg::ST_HISSUE: begin
        mac_ctl.clear = (kk == '0);
        if (kk == KW'(SLOTS)) begin
          state_next = sgb_pkg::ST_HWAIT;
        end
      end
      sgb_pkg::ST_HWAIT: begin
        if (wcnt) begin
          state_next = sgb_pkg::ST_HOUT;
        end
      end
      sgb_pkg::ST_HOUT: begin
        if (out_free) begin
          res_load = 1'b1;
          if (c_r == last_r) begin
            finish     = 1'b1;
            state_next = sgb_pkg::ST_IDLE;
          end else begin
            state_next = sgb_pkg::ST_HISSUE;
          end
        end
      end
      default: state_next = sgb_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sgb_pkg::ST_IDLE;
      column_count <= '0;
      row_count    <= '0;
      res_valid    <= 1'b0;
      s1_valid     <= 1'b0;
      kk           <= '0;
      wcnt         <= 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        row_window[i] <= '0;
      end
    end else begin
      state    <= state_next;
      s1_valid <= (state == sgb_pkg::ST_VISSUE) || (state == sgb_pkg::ST_HISSUE);
      // advance the tap index through each pass, then rewind
      if ((state == sgb_pkg::ST_VISSUE) || (state == sgb_pkg::ST_HISSUE)) begin
        kk <= (kk == KW'(SLOTS)) ? '0 : kk + KW'(1);
      end
      if ((state == sgb_pkg::ST_VWAIT) || (state == sgb_pkg::ST_HWAIT)) begin
        wcnt <= !wcnt;
      end
      // hold the rounded column sum in the window
      if (state == sgb_pkg::ST_VDONE) begin
        row_window[rx] <= mac_round;
      end
      if (finish) begin
        column_count <= col_adv;
        row_count    <= row_adv;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if ((state == sgb_pkg::ST_IDLE) && pix_valid) begin
      w_r      <= cur_w;
      h_r      <= cur_h;
      x_r      <= x_acc;
      y_r      <= y_acc;
      pix_r    <= pix_ext[PIXEL_BITS-1:0];
      in_img_r <= in_img;
    end
    if (state == sgb_pkg::ST_MOD) begin
      rx <= TW'(xrem);
      ry <= SW'(yrem);
    end
    s1_from_ram <= (state == sgb_pkg::ST_VISSUE);
    s1_usepix   <= v_usepix;
    s1_weight   <= weight;
    s1_win      <= row_window[hslot];
    // first and last output column of this word
    if (state == sgb_pkg::ST_VDONE) begin
      c_r    <= (32'(x_r) >= R) ? x_r - XW'(R) : '0;
      last_r <= x_last ? x_r : x_r - XW'(R);
    end
    if ((state == sgb_pkg::ST_HOUT) && out_free) begin
      c_r <= c_r + XW'(1);
    end
    if (res_load) begin
      res_data.value         <= sgb_pkg::PIX_W'(mac_round);
      res_data.column        <= sgb_pkg::COL_W'(c_r);
      res_data.row           <= sgb_pkg::ROW_W'(y_r - YW'(R));
      res_data.last_in_run   <= (c_r == last_r);
      res_data.last_of_image <= ({1'b0, c_r} == w_r - (XW+1)'(1)) &&
                                ((YW+1)'(y_r) == h_r + (YW+1)'(R - 1));
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == sgb_pkg::ST_IDLE) |-> !s1_valid)
    else $error("operand stage busy while idle");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (state == sgb_pkg::ST_VISSUE || state == sgb_pkg::ST_HISSUE) |->
      (32'(rx) < TAPS) && (32'(ry) < SLOTS))
    else $error("slot remainder out of range");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (32'(column_count) < MAX_WIDTH) && (32'(row_count) < MAX_HEIGHT + MAX_RADIUS))
    else $error("position counter out of range");

  a_frame_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.last_of_image) |-> res_data.last_in_run)
    else $error("frame end not on last word of run");
`endif

endmodule

`default_nettype wire

>>> rtl/sgb_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module sgb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/sgb_mac.sv
// Multiply-accumulate unit with round-half-up and saturation.
// Depends on sgb_pkg.
`default_nettype none

module sgb_mac #(
  parameter int PIX_BITS = 16,
  parameter int ACC_W    = 41
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire sgb_pkg::mac_ctl_t             ctl,
  input  wire logic [PIX_BITS-1:0]           sample,
  input  wire logic [sgb_pkg::COEF_W-1:0]    weight,
  output      logic [PIX_BITS-1:0]           rounded
);

  localparam int PW = sgb_pkg::COEF_W + PIX_BITS;
  localparam int SH = ACC_W - sgb_pkg::FRAC_W;

  logic [PW-1:0]    prod;
  logic             pvalid;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] biased;
  logic [SH-1:0]    shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
    end else begin
      pvalid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    prod <= PW'(weight) * PW'(sample);
    if (ctl.clear) begin
      acc <= '0;
    end else if (pvalid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // round half up, then clip to the pixel range
  always_comb begin
    biased  = acc + ACC_W'(sgb_pkg::RND_HALF);
    shifted = biased[ACC_W-1:sgb_pkg::FRAC_W];
    if (|shifted[SH-1:PIX_BITS]) begin
      rounded = '1;
    end else begin
      rounded = shifted[PIX_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/sgb_regs.sv
// APB register file: tap weights and frame size.
// Depends on sgb_pkg.
`default_nettype none

module sgb_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [sgb_pkg::ADDR_W-1:0] paddr,
  input  wire logic [sgb_pkg::DATA_W-1:0] pwdata,
  output      logic [sgb_pkg::DATA_W-1:0] prdata,
  output      logic                       pready,
  output      sgb_pkg::cfg_t              cfg
);

  sgb_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = sgb_pkg::reg_idx_t'(paddr[sgb_pkg::ADDR_W-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      // center tap sits in the low slice, all other taps clear
      cfg.coef         <= (sgb_pkg::NUM_COEF*sgb_pkg::COEF_W)'(sgb_pkg::COEF0_RESET);
      cfg.image_width  <= sgb_pkg::SIZE_RESET;
      cfg.image_height <= sgb_pkg::SIZE_RESET;
    end else if (wr) begin
      unique case (idx)
        sgb_pkg::REG_COEF_0:       cfg.coef[0] <= pwdata[sgb_pkg::COEF_W-1:0];
        sgb_pkg::REG_COEF_1:       cfg.coef[1] <= pwdata[sgb_pkg::COEF_W-1:0];
        sgb_pkg::REG_COEF_2:       cfg.coef[2] <= pwdata[sgb_pkg::COEF_W-1:0];
        sgb_pkg::REG_COEF_3:       cfg.coef[3] <= pwdata[sgb_pkg::COEF_W-1:0];
        sgb_pkg::REG_COEF_4:       cfg.coef[4] <= pwdata[sgb_pkg::COEF_W-1:0];
        sgb_pkg::REG_COEF_5:       cfg.coef[5] <= pwdata[sgb_pkg::COEF_W-1:0];
        sgb_pkg::REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[sgb_pkg::SIZE_W-1:0];
        sgb_pkg::REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[sgb_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sgb_pkg::REG_COEF_0:       prdata = sgb_pkg::DATA_W'(cfg.coef[0]);
      sgb_pkg::REG_COEF_1:       prdata = sgb_pkg::DATA_W'(cfg.coef[1]);
      sgb_pkg::REG_COEF_2:       prdata = sgb_pkg::DATA_W'(cfg.coef[2]);
      sgb_pkg::REG_COEF_3:       prdata = sgb_pkg::DATA_W'(cfg.coef[3]);
      sgb_pkg::REG_COEF_4:       prdata = sgb_pkg::DATA_W'(cfg.coef[4]);
      sgb_pkg::REG_COEF_5:       prdata = sgb_pkg::DATA_W'(cfg.coef[5]);
      sgb_pkg::REG_IMAGE_WIDTH:  prdata = sgb_pkg::DATA_W'(cfg.image_width);
      sgb_pkg::REG_IMAGE_HEIGHT: prdata = sgb_pkg::DATA_W'(cfg.image_height);
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> bench/sgb_checker.sv
// Checker for the separable Gaussian blur block: watches the pix, res and APB
// channels, predicts every result word and compares it. Depends on sgb_pkg.
module sgb_checker
  import sgb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              pix_valid,
  input  logic              pix_stall,
  input  pix_word_t         pix_data,
  input  logic              res_valid,
  input  logic              res_stall,
  input  res_word_t         res_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAD   = 5;
  localparam int SLOTS = 2 * RAD;
  localparam int TAPS  = 2 * RAD + 1;
  localparam int MAXW  = 1024;
  localparam int MAXH  = 1024;

  logic [COEF_W-1:0] k_coef [NUM_COEF];
  logic [SIZE_W-1:0] w_reg, h_reg;
  logic [PIX_W-1:0]  line_store [MAXW*SLOTS];
  logic [PIX_W-1:0]  vwin [TAPS];
  int                col_pos, row_pos;
  res_word_t         blur_q [$];

  function automatic longint unsigned weight(int d);
    if (d < 0) d = -d;
    return (d < NUM_COEF) ? longint'(k_coef[d]) : 0;
  endfunction

  function automatic logic [PIX_W-1:0] round_clip(longint unsigned acc);
    longint unsigned v;
    v = (acc + RND_HALF) >> FRAC_W;
    return (v > 65535) ? 16'hFFFF : v[PIX_W-1:0];
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Predict the result words caused by one accepted input word.
  task automatic blur_word(pix_word_t w);
    int              wd, ht, x, y, o, j, c, first, last, n;
    bit              in_img;
    longint unsigned acc;
    logic [PIX_W-1:0] v;
    res_word_t       r;
    wd = (w_reg == 0) ? 1 : ((w_reg > MAXW) ? MAXW : int'(w_reg));
    ht = (h_reg == 0) ? 1 : ((h_reg > MAXH) ? MAXH : int'(h_reg));
    x = (col_pos > wd - 1) ? wd - 1 : col_pos;
    y = (row_pos > ht + RAD - 1) ? ht + RAD - 1 : row_pos;
    in_img = (y < ht);
    if ((w.op == OP_DRAIN) == in_img) return;  // mismatched word: ignore
    o = y - RAD;
    acc = 0;
    for (int k = -RAD; k <= RAD; k++) begin
      j = clip(o + k, 0, ht - 1);
      v = (j == y) ? w.pixel : line_store[x*SLOTS + j%SLOTS];
      acc += weight(k) * v;
    end
    if (in_img) line_store[x*SLOTS + y%SLOTS] = w.pixel;
    vwin[x%TAPS] = round_clip(acc);
    if (o >= 0) begin
      first = (x - RAD < 0) ? 0 : x - RAD;
      last  = (x == wd - 1) ? wd - 1 : x - RAD;
      n = 0;
      for (c = first; c <= last; c++) begin
        acc = 0;
        for (int k = -RAD; k <= RAD; k++)
          acc += weight(k) * vwin[clip(c + k, 0, wd - 1) % TAPS];
        r.value         = round_clip(acc);
        r.column        = c[COL_W-1:0];
        r.row           = o[ROW_W-1:0];
        r.last_in_run   = (c == last);
        r.last_of_image = (c == wd - 1 && o == ht - 1);
        blur_q.push_back(r);
      end
    end
    if (x >= wd - 1) begin
      x = 0;
      y++;
      if (y >= ht + RAD) y = 0;
    end else begin
      x++;
    end
    col_pos = x;
    row_pos = y;
  endtask

  task automatic flag_fail(res_word_t e, res_word_t a);
    if (fail_count < 10)
      $display("blur mismatch: exp val=%0d col=%0d row=%0d lr=%0b li=%0b  got val=%0d col=%0d row=%0d lr=%0b li=%0b",
               e.value, e.column, e.row, e.last_in_run, e.last_of_image,
               a.value, a.column, a.row, a.last_in_run, a.last_of_image);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    res_word_t e;
    if (rst) begin
      foreach (k_coef[i]) k_coef[i] = '0;
      k_coef[0] = COEF0_RESET;
      w_reg = SIZE_RESET;
      h_reg = SIZE_RESET;
      foreach (line_store[i]) line_store[i] = '0;
      foreach (vwin[i]) vwin[i] = '0;
      col_pos = 0;
      row_pos = 0;
      blur_q.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (blur_q.size() == 0) begin
          if (fail_count < 10)
            $display("blur mismatch: unexpected word val=%0d col=%0d row=%0d",
                     res_data.value, res_data.column, res_data.row);
          fail_count++;
        end else begin
          e = blur_q.pop_front();
          if (e !== res_data) flag_fail(e, res_data);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_IMAGE_WIDTH:  w_reg = pwdata[SIZE_W-1:0];
          REG_IMAGE_HEIGHT: h_reg = pwdata[SIZE_W-1:0];
          default:          k_coef[paddr[4:2]] = pwdata[COEF_W-1:0];
        endcase
      end
      if (pix_valid && !pix_stall) blur_word(pix_data);
    end
    pending = blur_q.size();
  end
endmodule

>>> bench/tb_separable_gaussian_blur_top.sv
// Testbench top for separable_gaussian_blur_top: drives frames, drain rows and
// register writes, and gives the verdict. Depends on sgb_pkg and sgb_checker.
module tb_separable_gaussian_blur_top;
  import sgb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAD      = 5;
  localparam int LIMIT    = 4000000;
  localparam int SETTLE   = 250;   // > one word with six results in the block
  localparam int HOLD_LEN = 400;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              pix_valid = 1'b0;
  logic              pix_stall;
  pix_word_t         pix_data = '0;
  logic              res_valid;
  logic              res_stall = 1'b1;
  res_word_t         res_data;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int  fail_count, pending;
  int  cycles = 0;
  int  words_sent = 0;
  bit  pix_took = 0, res_took = 0;
  bit  hold_req = 0;    // ask the receiver for one long hold-off
  bit  send_burst = 0;  // no sender gaps while set

  always #10 clk = ~clk;

  separable_gaussian_blur_top DUT (
    .clk, .rst, .pix_valid, .pix_stall, .pix_data, .res_valid, .res_stall,
    .res_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sgb_checker chk (
    .clk, .rst, .pix_valid, .pix_stall, .pix_data, .res_valid, .res_stall,
    .res_data, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .pending
  );

  // Record handshakes so the drivers can see them after the edge settles.
  always @(posedge clk) begin
    pix_took <= pix_valid && !pix_stall;
    res_took <= res_valid && !res_stall;
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("separable_gaussian_blur_top: mismatch");
      $finish;
    end
  end

  // Receiver: random stall before each word, stretches with no stall, and one
  // long hold-off on request so the block backs up into its input.
  initial begin
    int gap;
    int burst_left;
    burst_left = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        res_stall = 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        hold_req = 0;
      end
      if (burst_left > 0) begin
        gap = 0;
        burst_left--;
      end else begin
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
        res_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      res_stall = 1'b0;
      // wait for a word to pass, then move on at the next falling edge
      do begin
        @(posedge clk);
        #1;
      end while (!res_took);
      @(negedge clk);
    end
  end

  // Offer one word; hold it until accepted.
  task automatic send_word(logic op, logic [PIX_W-1:0] pix);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      pix_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_data.op    = op;
    pix_data.pixel = pix;
    pix_valid      = 1'b1;
    do begin
      @(posedge clk);
      #1;
    end while (!pix_took);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic reg_write(reg_idx_t idx, int unsigned val);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Drop valid, then wait for every expected word plus the block's latency,
  // since words that yield no result may still be in flight.
  task automatic drain_out();
    pix_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_taps(int unsigned c0, c1, c2, c3, c4, c5);
    reg_write(REG_COEF_0, c0);
    reg_write(REG_COEF_1, c1);
    reg_write(REG_COEF_2, c2);
    reg_write(REG_COEF_3, c3);
    reg_write(REG_COEF_4, c4);
    reg_write(REG_COEF_5, c5);
  endtask

  task automatic random_taps();
    int unsigned t [6];
    case ($urandom_range(0, 3))
      0: foreach (t[i]) t[i] = $urandom_range(0, 65536);
      1: foreach (t[i]) t[i] = $urandom_range(0, 1) ? 65536 : 0;
      2: begin
        // smooth falloff
        t[0] = $urandom_range(12000, 30000);
        for (int i = 1; i < 6; i++) t[i] = t[i-1] * $urandom_range(30, 90) / 100;
      end
      default: foreach (t[i]) t[i] = $urandom_range(0, 1) ? $urandom_range(0, 65536) : 0;
    endcase
    set_taps(t[0], t[1], t[2], t[3], t[4], t[5]);
  endtask

  // One full frame of raster pixels plus the drain rows. noise is the percent
  // chance of slipping in a mismatched word, which the block ignores.
  task automatic run_frame(int unsigned wcfg, int unsigned hcfg, int noise,
                           int hold_at, bit extremes);
    int wd, ht, n;
    logic [PIX_W-1:0] p;
    reg_write(REG_IMAGE_WIDTH, wcfg);
    reg_write(REG_IMAGE_HEIGHT, hcfg);
    wd = (wcfg == 0) ? 1 : ((wcfg > 1024) ? 1024 : wcfg);
    ht = (hcfg == 0) ? 1 : ((hcfg > 1024) ? 1024 : hcfg);
    n = 0;
    for (int y = 0; y < ht + RAD; y++) begin
      for (int x = 0; x < wd; x++) begin
        if ($urandom_range(0, 99) < noise)
          send_word((y < ht) ? OP_DRAIN : OP_PIXEL, PIX_W'($urandom));
        if (extremes) p = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else          p = PIX_W'($urandom);
        if (n == hold_at) hold_req = 1;
        send_word((y < ht) ? OP_PIXEL : OP_DRAIN, p);
        n++;
      end
    end
    drain_out();
  endtask

  initial begin
    int rnd_start;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: sizes of 0 act as 1; one pixel at an extreme (0 or full scale) with stray words.
    set_taps(65536, 0, 0, 0, 0, 0);
    run_frame(0, 0, 60, -1, 1);
    // Full-weight taps saturate; pixels at both extremes, tiny frame.
    set_taps(65536, 65536, 65536, 65536, 65536, 65536);
    run_frame(3, 2, 20, -1, 1);
    set_taps(0, 0, 0, 0, 0, 0);
    run_frame(2, 1, 0, -1, 0);

    // Random small frames, clean or with a little noise.
    rnd_start = words_sent;
    while (words_sent - rnd_start < 250) begin
      random_taps();
      send_burst = ($urandom_range(0, 3) == 0);
      run_frame($urandom_range(1, 12), $urandom_range(1, 6),
                $urandom_range(0, 1) ? 0 : 5, -1, $urandom_range(0, 7) == 0);
    end

    // Long receiver hold-off while the sender keeps offering words.
    send_burst = 1;
    random_taps();
    run_frame(8, 4, 0, 10, 0);
    send_burst = 0;

    drain_out();
    if (fail_count == 0)
      $display("separable_gaussian_blur_top: match");
    else
      $display("separable_gaussian_blur_top: mismatch");
    $finish;
  end
endmodule

>>> filelist.f
rtl/sgb_pkg.sv
rtl/sgb_ram.sv
rtl/sgb_mac.sv
rtl/sgb_regs.sv
rtl/separable_gaussian_blur_top.sv
bench/sgb_checker.sv
bench/tb_separable_gaussian_blur_top.sv
